// File: src/gixs_pkg.sv
// gixs_pkg: shared types and constants for the grid interpolated lookup unit
// holds field widths, status and command codes, and the controller/datapath link
// depends on nothing

package gixs_pkg;

    // fixed field widths
    localparam int ENERGY_W  = 32;
    localparam int INDEX_W   = 10;
    localparam int POINTS_W  = 11;
    localparam int SURV_W    = 17;
    localparam int STATUS_W  = 3;
    localparam int SURV_FRAC = 16;

    // survival quotient: one integer bit and the fraction bits
    localparam int SURV_STEPS = SURV_FRAC + 1;

    localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(2);
    localparam logic [SURV_W-1:0]   SURV_ONE     = SURV_W'(65536);

    // item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSIDE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LAST   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOAD   = 3'd4;

    // table read address source
    typedef enum logic [1:0] {
        ADDR_LAST,
        ADDR_FIRST,
        ADDR_MID
    } t_addr_sel;

    // which values a result takes
    typedef enum logic [2:0] {
        RES_LOAD,
        RES_ABOVE,
        RES_LAST,
        RES_BELOW,
        RES_INTERP
    } t_res_kind;

    // controller to datapath commands
    typedef struct packed {
        logic      in_take;
        t_addr_sel addr_sel;
        logic      cap_hi;
        logic      cap_lo;
        logic      search_cap;
        logic      lerp_load;
        logic      lane_step;
        logic      surv_load;
        logic      res_set;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic q_ge_last;
        logic q_eq_last;
        logic q_lt_first;
        logic span_gt1;
    } t_dp_stat;

endpackage

// File: src/gixs_ram.sv
// gixs_ram: generic single write port, single read port memory
// read data is registered; no dependencies

module gixs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/gixs_muldiv.sv
// gixs_muldiv: bit-serial floor(a*b/c) for b < c, one bit of a per step
// remainder stays below c; up to two subtractions of c per step, done in parallel
// no package dependencies

module gixs_muldiv #(
    parameter int A_W = 32,
    parameter int C_W = 32
) (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_step,
    input  logic [A_W-1:0] i_a,
    input  logic [C_W-1:0] i_b,
    input  logic [C_W-1:0] i_c,
    output logic [A_W-1:0] o_q
);

    logic [A_W-1:0] r_a;
    logic [C_W-1:0] r_b;
    logic [C_W-1:0] r_c;
    logic [C_W:0]   r_c2;
    logic [C_W-1:0] r_r;
    logic [A_W-1:0] r_q;

    logic [C_W+1:0] w_sum;
    logic [C_W+1:0] w_sub1;
    logic [C_W+1:0] w_sub2;
    logic [C_W-1:0] n_r;
    logic [1:0]     w_k;
    logic [A_W-1:0] n_q;

    always_comb begin
        // 2r + b*bit, below 3c
        w_sum  = {1'b0, r_r, 1'b0} + (r_a[A_W-1] ? {2'b00, r_b} : '0);
        w_sub1 = w_sum - {2'b00, r_c};
        w_sub2 = w_sum - {1'b0, r_c2};
        priority if (w_sum >= {1'b0, r_c2}) begin
            n_r = C_W'(w_sub2);
            w_k = 2'd2;
        end else if (w_sum >= {2'b00, r_c}) begin
            n_r = C_W'(w_sub1);
            w_k = 2'd1;
        end else begin
            n_r = C_W'(w_sum);
            w_k = 2'd0;
        end
        n_q = {r_q[A_W-2:0], 1'b0} + A_W'(w_k);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_c  <= i_c;
            r_c2 <= {i_c, 1'b0};
            r_r  <= '0;
            r_q  <= '0;
        end else if (i_step) begin
            r_a <= {r_a[A_W-2:0], 1'b0};
            r_r <= n_r;
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// File: src/gixs_ctrl.sv
// gixs_ctrl: sequencing state machine of the lookup unit
// drives datapath commands and both handshakes; uses gixs_pkg

module gixs_ctrl #(
    parameter int LERP_STEPS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  gixs_pkg::t_dp_stat i_stat,
    output gixs_pkg::t_dp_cmd  o_cmd
);

    localparam int CNT_W = $clog2(LERP_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAP_LAST,
        S_CAP_FIRST,
        S_CLASSIFY,
        S_SRCH_RD,
        S_SRCH_CAP,
        S_LERP_LOAD,
        S_LERP_RUN,
        S_LERP_END,
        S_SURV_LOAD,
        S_SURV_RUN,
        S_DONE
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.addr_sel = gixs_pkg::ADDR_LAST;
        o_cmd.res_kind = gixs_pkg::RES_LOAD;
        unique case (r_state)
            S_IDLE: begin
                // keep the last grid entry read so a query starts with it
                o_cmd.addr_sel = gixs_pkg::ADDR_LAST;
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (i_cmd == gixs_pkg::CMD_LOAD) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = gixs_pkg::RES_LOAD;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_CAP_LAST;
                    end
                end
            end
            S_CAP_LAST: begin
                o_cmd.cap_hi   = 1'b1;
                o_cmd.addr_sel = gixs_pkg::ADDR_FIRST;
                n_state        = S_CAP_FIRST;
            end
            S_CAP_FIRST: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = S_CLASSIFY;
            end
            S_CLASSIFY: begin
                priority if (i_stat.q_ge_last) begin
                    o_cmd.res_set = 1'b1;
                    if (i_stat.q_eq_last) begin
                        o_cmd.res_kind = gixs_pkg::RES_LAST;
                        n_state        = S_SURV_LOAD;
                    end else begin
                        o_cmd.res_kind = gixs_pkg::RES_ABOVE;
                        n_state        = S_DONE;
                    end
                end else if (i_stat.q_lt_first) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = gixs_pkg::RES_BELOW;
                    n_state        = S_SURV_LOAD;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.span_gt1) begin
                    o_cmd.addr_sel = gixs_pkg::ADDR_MID;
                    n_state        = S_SRCH_CAP;
                end else begin
                    n_state = S_LERP_LOAD;
                end
            end
            S_SRCH_CAP: begin
                o_cmd.search_cap = 1'b1;
                n_state          = S_SRCH_RD;
            end
            S_LERP_LOAD: begin
                o_cmd.lerp_load = 1'b1;
                n_count         = CNT_W'(LERP_STEPS);
                n_state         = S_LERP_RUN;
            end
            S_LERP_RUN: begin
                o_cmd.lane_step = 1'b1;
                n_count         = r_count - 1'b1;
                if (r_count == CNT_W'(1)) begin
                    n_state = S_LERP_END;
                end
            end
            S_LERP_END: begin
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = gixs_pkg::RES_INTERP;
                n_state        = S_SURV_LOAD;
            end
            S_SURV_LOAD: begin
                o_cmd.surv_load = 1'b1;
                n_count         = CNT_W'(gixs_pkg::SURV_STEPS);
                n_state         = S_SURV_RUN;
            end
            S_SURV_RUN: begin
                o_cmd.lane_step = 1'b1;
                n_count         = r_count - 1'b1;
                if (r_count == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: src/gixs_dp.sv
// gixs_dp: datapath of the lookup unit: grid memory, search registers,
// two interpolation lanes, survival, result and output registers
// uses gixs_pkg, gixs_ram and gixs_muldiv

module gixs_dp #(
    parameter int MAX_POINTS  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gixs_pkg::POINTS_W-1:0]   i_cfg_data,
    input  logic                            i_cmd,
    input  logic [gixs_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic [gixs_pkg::ENERGY_W-1:0]   i_entry_energy,
    input  logic [VALUE_WIDTH-1:0]          i_entry_total,
    input  logic [VALUE_WIDTH-1:0]          i_entry_absorb,
    input  logic [gixs_pkg::ENERGY_W-1:0]   i_query_energy,
    input  gixs_pkg::t_dp_cmd               i_dp_cmd,
    output gixs_pkg::t_dp_stat              o_stat,
    output logic [VALUE_WIDTH-1:0]          o_total_value,
    output logic [VALUE_WIDTH-1:0]          o_absorb_value,
    output logic [gixs_pkg::SURV_W-1:0]     o_survival,
    output logic [gixs_pkg::STATUS_W-1:0]   o_status
);

    localparam int EW     = gixs_pkg::ENERGY_W;
    localparam int VW     = VALUE_WIDTH;
    localparam int IW     = $clog2(MAX_POINTS);
    localparam int WORD_W = EW + 2 * VW;
    localparam int LANE_A_W = (VW > gixs_pkg::SURV_STEPS) ? VW : gixs_pkg::SURV_STEPS;
    localparam int LANE_C_W = (VW > EW) ? VW : EW;
    localparam logic [LANE_A_W-1:0] SURV_A = {1'b1, {(LANE_A_W - 1){1'b0}}};

    // config register
    logic [gixs_pkg::POINTS_W-1:0] r_points;
    logic [IW-1:0]                 w_last;

    // memory port
    logic              w_we;
    logic [IW-1:0]     w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic [EW-1:0]     w_rd_e;
    logic [VW-1:0]     w_rd_t;
    logic [VW-1:0]     w_rd_a;

    // search state
    logic [EW-1:0] r_q;
    logic [IW-1:0] r_lo_idx;
    logic [EW-1:0] r_lo_e;
    logic [VW-1:0] r_lo_t;
    logic [VW-1:0] r_lo_a;
    logic [IW-1:0] r_hi_idx;
    logic [EW-1:0] r_hi_e;
    logic [VW-1:0] r_hi_t;
    logic [VW-1:0] r_hi_a;
    logic [IW-1:0] w_span;
    logic [IW-1:0] w_mid;

    // interpolation
    logic [VW-1:0]       w_d_t;
    logic [VW-1:0]       w_d_a;
    logic [EW-1:0]       w_dx;
    logic [EW-1:0]       w_de;
    logic                r_neg_t;
    logic                r_neg_a;
    logic                r_degen;
    logic                w_lane0_load;
    logic [LANE_A_W-1:0] w_lane0_a;
    logic [LANE_C_W-1:0] w_lane0_b;
    logic [LANE_C_W-1:0] w_lane0_c;
    logic [LANE_A_W-1:0] w_q0;
    logic [LANE_A_W-1:0] w_q1;
    logic [VW-1:0]       w_lerp_t;
    logic [VW-1:0]       w_lerp_a;

    // result
    logic [VW-1:0]                   r_tv;
    logic [VW-1:0]                   r_av;
    logic [gixs_pkg::STATUS_W-1:0]   r_st;
    logic [gixs_pkg::SURV_W-1:0]     w_surv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= gixs_pkg::POINTS_RESET;
        end else if (i_cfg_we) begin
            r_points <= i_cfg_data;
        end
    end

    // clamp the point count to the stored range
    always_comb begin
        priority if (r_points < gixs_pkg::POINTS_W'(2)) begin
            w_last = IW'(1);
        end else if (32'(r_points) > 32'(MAX_POINTS)) begin
            w_last = IW'(MAX_POINTS - 1);
        end else begin
            w_last = IW'(r_points - 1'b1);
        end
    end

    // loads beyond the table write nothing
    assign w_we = i_dp_cmd.in_take && (i_cmd == gixs_pkg::CMD_LOAD)
               && (32'(i_entry_index) < 32'(MAX_POINTS));

    assign w_span = r_hi_idx - r_lo_idx;
    assign w_mid  = r_lo_idx + (w_span >> 1);

    always_comb begin
        unique case (i_dp_cmd.addr_sel)
            gixs_pkg::ADDR_LAST:  w_raddr = w_last;
            gixs_pkg::ADDR_FIRST: w_raddr = '0;
            gixs_pkg::ADDR_MID:   w_raddr = w_mid;
            default:              w_raddr = w_last;
        endcase
    end

    gixs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(i_entry_index)),
        .i_wdata ({i_entry_energy, i_entry_total, i_entry_absorb}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_e = w_rdata[2*VW +: EW];
    assign w_rd_t = w_rdata[VW +: VW];
    assign w_rd_a = w_rdata[0 +: VW];

    assign o_stat.q_ge_last  = (r_q >= r_hi_e);
    assign o_stat.q_eq_last  = (r_q == r_hi_e);
    assign o_stat.q_lt_first = (r_q < r_lo_e);
    assign o_stat.span_gt1   = (w_span > IW'(1));

    // bin deltas
    assign w_d_t = (r_hi_t >= r_lo_t) ? (r_hi_t - r_lo_t) : (r_lo_t - r_hi_t);
    assign w_d_a = (r_hi_a >= r_lo_a) ? (r_hi_a - r_lo_a) : (r_lo_a - r_hi_a);
    assign w_dx  = r_q - r_lo_e;
    assign w_de  = r_hi_e - r_lo_e;

    // lane 0 also serves the survival division
    assign w_lane0_load = i_dp_cmd.lerp_load | i_dp_cmd.surv_load;
    assign w_lane0_a = i_dp_cmd.surv_load ? SURV_A : LANE_A_W'(w_d_t);
    assign w_lane0_b = i_dp_cmd.surv_load ? LANE_C_W'(r_tv - r_av) : LANE_C_W'(w_dx);
    assign w_lane0_c = i_dp_cmd.surv_load ? LANE_C_W'(r_tv) : LANE_C_W'(w_de);

    gixs_muldiv #(
        .A_W (LANE_A_W),
        .C_W (LANE_C_W)
    ) u_lane_total (
        .i_clk  (i_clk),
        .i_load (w_lane0_load),
        .i_step (i_dp_cmd.lane_step),
        .i_a    (w_lane0_a),
        .i_b    (w_lane0_b),
        .i_c    (w_lane0_c),
        .o_q    (w_q0)
    );

    gixs_muldiv #(
        .A_W (LANE_A_W),
        .C_W (LANE_C_W)
    ) u_lane_absorb (
        .i_clk  (i_clk),
        .i_load (i_dp_cmd.lerp_load),
        .i_step (i_dp_cmd.lane_step),
        .i_a    (LANE_A_W'(w_d_a)),
        .i_b    (LANE_C_W'(w_dx)),
        .i_c    (LANE_C_W'(w_de)),
        .o_q    (w_q1)
    );

    // step toward the upper point, or hold the lower point in a bad bin
    always_comb begin
        priority if (r_degen) begin
            w_lerp_t = r_lo_t;
            w_lerp_a = r_lo_a;
        end else begin
            w_lerp_t = r_neg_t ? (r_lo_t - VW'(w_q0)) : (r_lo_t + VW'(w_q0));
            w_lerp_a = r_neg_a ? (r_lo_a - VW'(w_q1)) : (r_lo_a + VW'(w_q1));
        end
    end

    always_comb begin
        priority if ((r_tv == '0) || (r_av >= r_tv)) begin
            w_surv = '0;
        end else if (r_av == '0) begin
            w_surv = gixs_pkg::SURV_ONE;
        end else begin
            w_surv = gixs_pkg::SURV_W'(w_q0[gixs_pkg::SURV_FRAC-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.in_take) begin
            r_q <= i_query_energy;
        end
        if (i_dp_cmd.cap_hi) begin
            r_hi_idx <= w_last;
            r_hi_e   <= w_rd_e;
            r_hi_t   <= w_rd_t;
            r_hi_a   <= w_rd_a;
        end
        if (i_dp_cmd.cap_lo) begin
            r_lo_idx <= '0;
            r_lo_e   <= w_rd_e;
            r_lo_t   <= w_rd_t;
            r_lo_a   <= w_rd_a;
        end
        if (i_dp_cmd.search_cap) begin
            if (w_rd_e <= r_q) begin
                r_lo_idx <= w_mid;
                r_lo_e   <= w_rd_e;
                r_lo_t   <= w_rd_t;
                r_lo_a   <= w_rd_a;
            end else begin
                r_hi_idx <= w_mid;
                r_hi_e   <= w_rd_e;
                r_hi_t   <= w_rd_t;
                r_hi_a   <= w_rd_a;
            end
        end
        if (i_dp_cmd.lerp_load) begin
            r_neg_t <= (r_hi_t < r_lo_t);
            r_neg_a <= (r_hi_a < r_lo_a);
            r_degen <= (r_hi_e <= r_lo_e) || (r_q < r_lo_e) || (r_q >= r_hi_e);
        end
        if (i_dp_cmd.res_set) begin
            unique case (i_dp_cmd.res_kind)
                gixs_pkg::RES_LOAD: begin
                    r_tv <= '0;
                    r_av <= '0;
                    r_st <= gixs_pkg::ST_LOAD;
                end
                gixs_pkg::RES_ABOVE: begin
                    r_tv <= '0;
                    r_av <= '0;
                    r_st <= gixs_pkg::ST_ABOVE;
                end
                gixs_pkg::RES_LAST: begin
                    r_tv <= r_hi_t;
                    r_av <= r_hi_a;
                    r_st <= gixs_pkg::ST_LAST;
                end
                gixs_pkg::RES_BELOW: begin
                    r_tv <= r_lo_t;
                    r_av <= r_lo_a;
                    r_st <= gixs_pkg::ST_BELOW;
                end
                gixs_pkg::RES_INTERP: begin
                    r_tv <= w_lerp_t;
                    r_av <= w_lerp_a;
                    r_st <= gixs_pkg::ST_INSIDE;
                end
                default: begin
                    r_tv <= '0;
                    r_av <= '0;
                    r_st <= gixs_pkg::ST_LOAD;
                end
            endcase
        end
        if (i_dp_cmd.out_load) begin
            o_total_value  <= r_tv;
            o_absorb_value <= r_av;
            o_survival     <= w_surv;
            o_status       <= r_st;
        end
    end

endmodule

// File: src/grid_interpolated_xs_lookup_unit.sv
// grid_interpolated_xs_lookup_unit: top level of the grid interpolated lookup unit
// joins the controller (gixs_ctrl) and the datapath (gixs_dp); uses gixs_pkg

// The unit stores an ascending grid of energy codes with a total and an absorption
// value per point. A load item (cmd 0) writes one entry and returns zeros with
// status 4. A query item (cmd 1) finds the bin of the first points_in_use entries
// that holds the energy, interpolates both values linearly (step rounded toward
// the lower point) and returns survival = 1 - absorb/total in Q1.16, saturated to
// zero. Status is 0 inside the grid, 1 exactly on the last point, 2 above it
// (values zero) and 3 below the first point (first entries returned).
// One item is worked on at a time. The interpolation is bit-serial and the bin
// search reads the grid through the one registered read port of the grid memory.
// A query on the last point or below the first skips the search and the
// interpolation, and one above the grid also skips the survival division. A
// finished result waits in the output register and the next item is accepted
// meanwhile. Grid entries hold no reset value; every entry a query can reach must
// be loaded first. The user must write points_in_use only while idle; the block
// itself does not enforce it.

module grid_interpolated_xs_lookup_unit #(
    parameter int MAX_POINTS  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration: points_in_use
    input  logic                            i_cfg_we,
    input  logic [gixs_pkg::POINTS_W-1:0]   i_cfg_data,

    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [gixs_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic [gixs_pkg::ENERGY_W-1:0]   i_entry_energy,
    input  logic [VALUE_WIDTH-1:0]          i_entry_total,
    input  logic [VALUE_WIDTH-1:0]          i_entry_absorb,
    input  logic [gixs_pkg::ENERGY_W-1:0]   i_query_energy,

    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [VALUE_WIDTH-1:0]          o_total_value,
    output logic [VALUE_WIDTH-1:0]          o_absorb_value,
    output logic [gixs_pkg::SURV_W-1:0]     o_survival,
    output logic [gixs_pkg::STATUS_W-1:0]   o_status
);

    // interpolation lanes run one bit of the value delta per cycle
    localparam int LERP_STEPS =
        (VALUE_WIDTH > gixs_pkg::SURV_STEPS) ? VALUE_WIDTH : gixs_pkg::SURV_STEPS;

    gixs_pkg::t_dp_cmd  w_dp_cmd;
    gixs_pkg::t_dp_stat w_stat;

    // sequencing: table reads, search steps, lane runs, output handoff
    gixs_ctrl #(
        .LERP_STEPS (LERP_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_dp_cmd)
    );

    // grid memory, search registers, interpolation and survival arithmetic
    gixs_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_entry_energy (i_entry_energy),
        .i_entry_total  (i_entry_total),
        .i_entry_absorb (i_entry_absorb),
        .i_query_energy (i_query_energy),
        .i_dp_cmd       (w_dp_cmd),
        .o_stat         (w_stat),
        .o_total_value  (o_total_value),
        .o_absorb_value (o_absorb_value),
        .o_survival     (o_survival),
        .o_status       (o_status)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for grid_interpolated_xs_lookup_unit, load and query items
// over valid/ready, every result predicted and compared in a small scoreboard class
// depends on gixs_pkg and grid_interpolated_xs_lookup_unit

module tb;

    localparam int MAX_PTS     = 1024;
    localparam int VAL_W       = 32;
    localparam int CYCLE_CAP   = 1_000_000;
    localparam int PHASE_ITEMS = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic                          cmd;
        logic [gixs_pkg::INDEX_W-1:0]  index;
        logic [gixs_pkg::ENERGY_W-1:0] energy;
        logic [VAL_W-1:0]              total;
        logic [VAL_W-1:0]              absorb;
        logic [gixs_pkg::ENERGY_W-1:0] query;
    } t_lookup_item;

    typedef struct packed {
        logic [VAL_W-1:0]              total;
        logic [VAL_W-1:0]              absorb;
        logic [gixs_pkg::SURV_W-1:0]   survival;
        logic [gixs_pkg::STATUS_W-1:0] status;
    } t_lookup_result;

    // own copy of the grid and the register, expected results in arrival order
    class xs_lookup_scoreboard;
        logic [gixs_pkg::ENERGY_W-1:0] grid_energy [MAX_PTS];
        logic [VAL_W-1:0]              total_tab   [MAX_PTS];
        logic [VAL_W-1:0]              absorb_tab  [MAX_PTS];
        logic [gixs_pkg::POINTS_W-1:0] points_reg;
        t_lookup_result                awaited [$];
        int unsigned                   mismatches;
        int unsigned                   status_count [8];

        function new();
            points_reg = gixs_pkg::POINTS_RESET;
            mismatches = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        // register values outside 2..MAX_PTS are clamped
        function int unsigned points_eff();
            if (points_reg < 2) return 2;
            if (points_reg > MAX_PTS) return MAX_PTS;
            return points_reg;
        endfunction

        // step toward y1, truncated so it rounds toward y0
        function logic [VAL_W-1:0] lerp(input logic [gixs_pkg::ENERGY_W-1:0] e0, e1, q,
                                        input logic [VAL_W-1:0] y0, y1);
            logic [63:0] step;
            if (e1 <= e0 || q < e0 || q >= e1) return y0;
            if (y1 >= y0) begin
                step = (64'(y1 - y0) * 64'(q - e0)) / 64'(e1 - e0);
                return y0 + step[VAL_W-1:0];
            end
            step = (64'(y0 - y1) * 64'(q - e0)) / 64'(e1 - e0);
            return y0 - step[VAL_W-1:0];
        endfunction

        function logic [gixs_pkg::SURV_W-1:0] survival_of(input logic [VAL_W-1:0] t, a);
            logic [63:0] frac;
            if (t == 0 || a >= t) return '0;
            if (a == 0) return gixs_pkg::SURV_ONE;
            frac = (64'(t - a) << gixs_pkg::SURV_FRAC) / 64'(t);
            return frac[gixs_pkg::SURV_W-1:0];
        endfunction

        function t_lookup_result predict_lookup(input t_lookup_item it);
            t_lookup_result r;
            int unsigned    last, lo, hi, mid;
            r = '0;
            if (it.cmd == gixs_pkg::CMD_LOAD) begin
                grid_energy[it.index] = it.energy;
                total_tab[it.index]   = it.total;
                absorb_tab[it.index]  = it.absorb;
                r.status = gixs_pkg::ST_LOAD;
                return r;
            end
            last = points_eff() - 1;
            if (it.query < grid_energy[last]) begin
                if (it.query < grid_energy[0]) begin
                    r.total  = total_tab[0];
                    r.absorb = absorb_tab[0];
                    r.status = gixs_pkg::ST_BELOW;
                end else begin
                    lo = 0;
                    hi = last;
                    while (hi - lo > 1) begin
                        mid = lo + (hi - lo) / 2;
                        if (grid_energy[mid] <= it.query) lo = mid;
                        else hi = mid;
                    end
                    r.total  = lerp(grid_energy[lo], grid_energy[lo+1], it.query,
                                    total_tab[lo], total_tab[lo+1]);
                    r.absorb = lerp(grid_energy[lo], grid_energy[lo+1], it.query,
                                    absorb_tab[lo], absorb_tab[lo+1]);
                    r.status = gixs_pkg::ST_INSIDE;
                end
            end else if (it.query == grid_energy[last]) begin
                r.total  = total_tab[last];
                r.absorb = absorb_tab[last];
                r.status = gixs_pkg::ST_LAST;
            end else begin
                r.status = gixs_pkg::ST_ABOVE;
            end
            r.survival = survival_of(r.total, r.absorb);
            return r;
        endfunction

        function void note_item(input t_lookup_item it);
            awaited.push_back(predict_lookup(it));
        endfunction

        function void compare_field(input string name, input logic [63:0] want, got);
            if (want !== got) begin
                $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input t_lookup_result got);
            t_lookup_result want;
            if (awaited.size() == 0) begin
                $display("%0t unexpected result: expected none actual status %0d total %h",
                         $time, got.status, got.total);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            status_count[want.status]++;
            compare_field("total_value", want.total, got.total);
            compare_field("absorb_value", want.absorb, got.absorb);
            compare_field("survival", want.survival, got.survival);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [gixs_pkg::POINTS_W-1:0]   i_cfg_data     = '0;
    logic                            i_in_valid     = 1'b0;
    logic                            o_in_ready;
    logic                            i_cmd          = gixs_pkg::CMD_LOAD;
    logic [gixs_pkg::INDEX_W-1:0]    i_entry_index  = '0;
    logic [gixs_pkg::ENERGY_W-1:0]   i_entry_energy = '0;
    logic [VAL_W-1:0]                i_entry_total  = '0;
    logic [VAL_W-1:0]                i_entry_absorb = '0;
    logic [gixs_pkg::ENERGY_W-1:0]   i_query_energy = '0;
    logic                            o_out_valid;
    logic                            i_out_ready    = 1'b0;
    logic [VAL_W-1:0]                o_total_value;
    logic [VAL_W-1:0]                o_absorb_value;
    logic [gixs_pkg::SURV_W-1:0]     o_survival;
    logic [gixs_pkg::STATUS_W-1:0]   o_status;

    xs_lookup_scoreboard sb = new();

    bit          quiet_run    = 1'b0;
    bit          sink_hold_go = 1'b0;
    int unsigned cycle_count  = 0;
    int unsigned loads_sent   = 0;
    int unsigned queries_sent = 0;
    int unsigned cfg_writes   = 0;
    logic [gixs_pkg::ENERGY_W-1:0] grid_base = '0;
    logic [gixs_pkg::ENERGY_W-1:0] grid_step = 32'd1;

    grid_interpolated_xs_lookup_unit #(
        .MAX_POINTS  (MAX_PTS),
        .VALUE_WIDTH (VAL_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_entry_energy (i_entry_energy),
        .i_entry_total  (i_entry_total),
        .i_entry_absorb (i_entry_absorb),
        .i_query_energy (i_query_energy),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_total_value  (o_total_value),
        .o_absorb_value (o_absorb_value),
        .o_survival     (o_survival),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("%0t watchdog expired, %0d results outstanding", $time, sb.awaited.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // a break with about 9 percent chance, none during a quiet run
    function automatic bit take_break();
        return !quiet_run && ($urandom_range(0, 99) < 9);
    endfunction

    // result side: sample at the edge, then pick ready for the next cycle
    initial begin : result_sink
        int unsigned    hold_left;
        t_lookup_result got;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got = {o_total_value, o_absorb_value, o_survival, o_status};
                sb.check_result(got);
            end
            if (sink_hold_go) begin
                sink_hold_go = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !take_break();
            end
        end
    end

    task automatic send_item(input t_lookup_item it);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= it.cmd;
        i_entry_index  <= it.index;
        i_entry_energy <= it.energy;
        i_entry_total  <= it.total;
        i_entry_absorb <= it.absorb;
        i_query_energy <= it.query;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        if (it.cmd == gixs_pkg::CMD_LOAD) loads_sent++;
        else queries_sent++;
    endtask

    // sender stops until every expected result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic write_points(input logic [gixs_pkg::POINTS_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.points_reg = v;
        cfg_writes++;
    endtask

    function automatic t_lookup_item load_item(input int unsigned idx,
                                               input logic [31:0] e, t, a);
        t_lookup_item it;
        it.cmd    = gixs_pkg::CMD_LOAD;
        it.index  = gixs_pkg::INDEX_W'(idx);
        it.energy = e;
        it.total  = t;
        it.absorb = a;
        it.query  = $urandom;
        return it;
    endfunction

    function automatic t_lookup_item query_item(input logic [31:0] q);
        t_lookup_item it;
        it.cmd    = gixs_pkg::CMD_QUERY;
        it.index  = gixs_pkg::INDEX_W'($urandom);
        it.energy = $urandom;
        it.total  = $urandom;
        it.absorb = $urandom;
        it.query  = q;
        return it;
    endfunction

    // ascending energies: base + idx*step plus jitter of up to half a step
    function automatic void new_scheme(input int unsigned span);
        grid_base = $urandom_range(0, 32'h8000_0000);
        grid_step = (32'hFFFF_FFFF - grid_base) / (span + 1);
        if (grid_step == 0) grid_step = 1;
        grid_step = $urandom_range(1, grid_step);
    endfunction

    function automatic logic [31:0] scheme_energy(input int unsigned idx);
        return grid_base + idx * grid_step + $urandom_range(0, grid_step / 2);
    endfunction

    function automatic t_lookup_item random_load(input int unsigned idx);
        logic [31:0] t, a, e;
        int unsigned pick;
        t    = ($urandom_range(0, 99) < 5) ? 32'd0 : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 70) a = $urandom_range(0, t);
        else if (pick < 80) a = t;
        else a = $urandom;
        // a few loads break the ascending order
        e = ($urandom_range(0, 99) < 90) ? scheme_energy(idx) : $urandom;
        return load_item(idx, e, t, a);
    endfunction

    function automatic t_lookup_item ordered_load(input int unsigned idx);
        t_lookup_item it;
        it        = random_load(idx);
        it.energy = scheme_energy(idx);
        return it;
    endfunction

    function automatic t_lookup_item random_query();
        int unsigned last, k, pick;
        logic [31:0] q;
        last = sb.points_eff() - 1;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            q = sb.grid_energy[$urandom_range(0, last)];
        end else if (pick < 70) begin
            k = $urandom_range(0, last - 1);
            q = $urandom_range(sb.grid_energy[k], sb.grid_energy[k+1]);
        end else if (pick < 80) begin
            q = $urandom_range(0, sb.grid_energy[0]);
        end else if (pick < 90) begin
            q = $urandom_range(sb.grid_energy[last], 32'hFFFF_FFFF);
        end else begin
            q = $urandom;
        end
        return query_item(q);
    endfunction

    // one register setting: small grids get fresh ordered contents first
    task automatic run_phase(input logic [gixs_pkg::POINTS_W-1:0] pts,
                             input int unsigned count);
        int unsigned span, idx;
        write_points(pts);
        span = sb.points_eff();
        if (span <= 64) begin
            new_scheme(span);
            for (int i = 0; i < span; i++) send_item(ordered_load(i));
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 25) begin
                idx = ($urandom_range(0, 99) < 80) ? $urandom_range(0, span - 1)
                                                   : $urandom_range(0, MAX_PTS - 1);
                send_item(random_load(idx));
            end else begin
                send_item(random_query());
            end
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two-point grid (register zero acts as two)
        write_points('0);
        send_item(load_item(0, 32'd1000, 32'hFFFF_FFFF, 32'd0));
        send_item(load_item(1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
        send_item(query_item(32'd0));            // below first point
        send_item(query_item(32'd999));
        send_item(query_item(32'd1000));         // on first point, full survival
        send_item(query_item(32'h8000_0000));    // total falls, absorption rises
        send_item(query_item(32'hFFFF_FFFE));
        send_item(query_item(32'hFFFF_FFFF));    // on last point, zero total
        send_item(load_item(1, 32'd5000, 32'h0001_0000, 32'h0001_0000));
        send_item(query_item(32'd3000));
        send_item(query_item(32'd5000));         // absorption equals total
        send_item(query_item(32'd5001));         // above grid
        send_item(query_item(32'hFFFF_FFFF));
        send_item(load_item(0, 32'd0, 32'd0, 32'd0));
        send_item(query_item(32'd0));            // zero total inside
        send_item(load_item(1, 32'd1, 32'd5, 32'hFFFF_FFFF));
        send_item(query_item(32'd1));            // absorption above total
        send_item(query_item(32'd0));
        send_item(load_item(MAX_PTS - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // fill the whole grid in order; long sink hold early, quiet stretch later
        write_points(11'h7FF);
        new_scheme(MAX_PTS);
        for (int i = 0; i < MAX_PTS; i++) begin
            if (i == 300) sink_hold_go = 1'b1;
            quiet_run = (i >= 500 && i < 900);
            send_item(ordered_load(i));
        end
        quiet_run = 1'b0;

        // large settings first, then small ones that reload their own points
        run_phase(11'd1025, PHASE_ITEMS);
        run_phase(11'd1024, PHASE_ITEMS);
        run_phase(11'h7FF, PHASE_ITEMS);
        run_phase(11'd700, PHASE_ITEMS);
        run_phase(11'd64, PHASE_ITEMS);
        run_phase(11'd1, PHASE_ITEMS);
        run_phase(11'd0, PHASE_ITEMS);
        run_phase(11'd3, PHASE_ITEMS);
        run_phase(11'd17, PHASE_ITEMS);
        run_phase(11'd2, PHASE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d loads and %0d queries across %0d register writes",
                 loads_sent, queries_sent, cfg_writes);
        $display("query outcomes: inside %0d, last point %0d, above %0d, below %0d",
                 sb.status_count[gixs_pkg::ST_INSIDE], sb.status_count[gixs_pkg::ST_LAST],
                 sb.status_count[gixs_pkg::ST_ABOVE], sb.status_count[gixs_pkg::ST_BELOW]);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: grid_interpolated_xs_lookup_unit.f
src/gixs_pkg.sv
src/gixs_ram.sv
src/gixs_muldiv.sv
src/gixs_ctrl.sv
src/gixs_dp.sv
src/grid_interpolated_xs_lookup_unit.sv
sim/tb.sv
